### rtl/engine_speed_thermal_step_core_assert.svh
// Assertion macros for the engine speed and thermal step core
`ifndef ENGINE_SPEED_THERMAL_STEP_CORE_ASSERT_SVH
`define ENGINE_SPEED_THERMAL_STEP_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define ESTC_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ESTC_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/estc_pkg.sv
// Shared types, codes and helpers of the engine speed and thermal step core
package estc_pkg;

	localparam int POINTS_DEF = 8;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [2:0] CFG_INERTIA    = 3'd0;
	localparam logic [2:0] CFG_OVERHEAT   = 3'd1;
	localparam logic [2:0] CFG_HEAT_TRQ   = 3'd2;
	localparam logic [2:0] CFG_HEAT_SPDSQ = 3'd3;
	localparam logic [2:0] CFG_COOLING    = 3'd4;
	localparam logic [2:0] CFG_AMBIENT    = 3'd5;
	localparam logic [2:0] CFG_POINTS     = 3'd6;

	typedef struct packed {
		logic signed [31:0] torque;
		logic signed [31:0] speed;
	} curve_pt_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START_RD,
		ST_ACC_DIV,
		ST_SPD_MUL,
		ST_SPD_ADD,
		ST_SRCH_WAIT,
		ST_SRCH_CMP,
		ST_INT_DIV,
		ST_INT_MUL,
		ST_INT_ADD,
		ST_TMP_M1,
		ST_TMP_M2,
		ST_TMP_ADD,
		ST_R_SQ,
		ST_R_SQ2,
		ST_R_H1,
		ST_R_H2,
		ST_R_COOL,
		ST_R_PWR,
		ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

### rtl/estc_mul.sv
// Shared signed multiplier with registered product
module estc_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

### rtl/estc_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle
module estc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  estc_pkg::div_req_t  req,
	output estc_pkg::div_rsp_t  rsp
);
	import estc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [32:0] rem_q;
	logic [63:0] dvd_q;
	logic [32:0] dsr_q;
	logic [33:0] trial;
	logic        fits;

	assign trial = {rem_q, dvd_q[63]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			// shift quotient bits in where dividend bits leave
			rem_q <= fits ? 33'(trial - {1'b0, dsr_q}) : trial[32:0];
			dvd_q <= {dvd_q[62:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;
endmodule

### rtl/estc_curve.sv
// Torque curve point memory, one write and one registered read port
module estc_curve #(
	parameter int POINTS = estc_pkg::POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(POINTS)-1:0]   waddr,
	input  estc_pkg::curve_pt_t         wdata,
	input  logic [$clog2(POINTS)-1:0]   raddr,
	output estc_pkg::curve_pt_t         rdata
);
	import estc_pkg::*;

	curve_pt_t mem [POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/engine_speed_thermal_step_core.sv
// Engine model: torque curve lookup, speed and temperature integration.
// Load and unknown transactions: result 1 cycle after acceptance.
// Start: loads speed and torque from curve point 0, temperature from ambient, then rates.
// Tick: divide on the shared divider, serial curve search, optional second divide, rates.
// One transaction at a time; input stalls until the result is taken.
// Reset sets state and configuration to their defaults; curve memory stays undefined until loaded.
module engine_speed_thermal_step_core #(
	parameter int POINTS = estc_pkg::POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [2:0]         point_index,
	input  logic signed [31:0] point_torque,
	input  logic signed [31:0] point_speed,
	input  logic [23:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] speed_out,
	output logic signed [31:0] torque_out,
	output logic signed [47:0] power_out,
	output logic signed [31:0] temperature_out,
	output logic signed [31:0] temp_change_rate,
	output logic               overheated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import estc_pkg::*;
	`include "engine_speed_thermal_step_core_assert.svh"

	localparam int IW = $clog2(POINTS);
	localparam int KW = $clog2(POINTS + 1);

	state_t state_q, state_d;

	logic [30:0]        inertia_q;
	logic signed [31:0] overheat_q, hpt_q, hpsq_q, cf_q, ambient_q;
	logic [3:0]         pts_q;

	logic signed [31:0] speed_q, torque_q, temp_q, heat_q, cool_q;
	logic signed [47:0] power_q;
	logic signed [31:0] accel_q, sq_q;
	logic signed [63:0] acc_q;
	logic [23:0]        dt_q;
	logic [KW-1:0]      k_q, n_act;
	logic [30:0]        t_q;
	curve_pt_t          prev_q, cur_q, rd_pt;

	logic               accept;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] p16;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [31:0]        trq_mag;
	logic [63:0]        q;
	logic               load_we;

	assign accept  = in_valid && !in_stall;
	assign load_we = accept && (req_type == REQ_LOAD) && ({29'd0, point_index} < 32'(POINTS));
	assign p16     = 64'(mul_p >>> 16);
	assign q       = div_rsp.quotient;

	always_comb begin
		if (pts_q == 4'd0) begin
			n_act = KW'(1);
		end else if ({28'd0, pts_q} > 32'(POINTS)) begin
			n_act = KW'(POINTS);
		end else begin
			n_act = KW'(pts_q);
		end
	end

	assign trq_mag = torque_q[31] ? 32'(-{torque_q[31], torque_q}) : 32'(torque_q);

	estc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
	estc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	estc_curve #(.POINTS(POINTS)) u_curve (
		.clk(clk), .we(load_we), .waddr(IW'(point_index)),
		.wdata('{torque: point_torque, speed: point_speed}),
		.raddr(k_q[IW-1:0]), .rdata(rd_pt)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q  <= 31'd65536;
			overheat_q <= 32'sd7208960;
			hpt_q      <= '0;
			hpsq_q     <= '0;
			cf_q       <= '0;
			ambient_q  <= 32'sd1310720;
			pts_q      <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INERTIA:    inertia_q  <= cfg_wdata[30:0];
				CFG_OVERHEAT:   overheat_q <= cfg_wdata;
				CFG_HEAT_TRQ:   hpt_q      <= cfg_wdata;
				CFG_HEAT_SPDSQ: hpsq_q     <= cfg_wdata;
				CFG_COOLING:    cf_q       <= cfg_wdata;
				CFG_AMBIENT:    ambient_q  <= cfg_wdata;
				CFG_POINTS:     pts_q      <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_START: state_d = ST_START_RD;
						REQ_TICK: begin
							div_req.start    = 1'b1;
							div_req.dividend = {16'd0, trq_mag, 16'd0};
							div_req.divisor  = (inertia_q == '0) ? 33'd1 : {2'b0, inertia_q};
							state_d          = ST_ACC_DIV;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_START_RD: state_d = ST_R_SQ;
			ST_ACC_DIV:  if (div_rsp.done) state_d = ST_SPD_MUL;
			ST_SPD_MUL: begin
				mul_a   = 33'(accel_q);
				mul_b   = {9'd0, dt_q};
				state_d = ST_SPD_ADD;
			end
			ST_SPD_ADD:  state_d = ST_SRCH_WAIT;
			ST_SRCH_WAIT: state_d = (k_q == n_act) ? ST_TMP_M1 : ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				if (rd_pt.speed < speed_q) begin
					state_d = ST_SRCH_WAIT;
				end else if (k_q == '0) begin
					state_d = ST_TMP_M1;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {31'd0, 33'(33'(speed_q) - 33'(prev_q.speed))} << 30;
					div_req.divisor  = 33'(33'(rd_pt.speed) - 33'(prev_q.speed));
					state_d          = ST_INT_DIV;
				end
			end
			ST_INT_DIV: if (div_rsp.done) state_d = ST_INT_MUL;
			ST_INT_MUL: begin
				mul_a   = 33'(cur_q.torque) - 33'(prev_q.torque);
				mul_b   = {2'b0, t_q};
				state_d = ST_INT_ADD;
			end
			ST_INT_ADD: state_d = ST_TMP_M1;
			ST_TMP_M1: begin
				mul_a   = 33'(heat_q);
				mul_b   = {9'd0, dt_q};
				state_d = ST_TMP_M2;
			end
			ST_TMP_M2: begin
				mul_a   = 33'(cool_q);
				mul_b   = {9'd0, dt_q};
				state_d = ST_TMP_ADD;
			end
			ST_TMP_ADD: state_d = ST_R_SQ;
			ST_R_SQ: begin
				mul_a   = 33'(speed_q);
				mul_b   = 33'(speed_q);
				state_d = ST_R_SQ2;
			end
			ST_R_SQ2: begin
				mul_a   = 33'(torque_q);
				mul_b   = 33'(hpt_q);
				state_d = ST_R_H1;
			end
			ST_R_H1: begin
				mul_a   = 33'(sq_q);
				mul_b   = 33'(hpsq_q);
				state_d = ST_R_H2;
			end
			ST_R_H2: begin
				mul_a   = 33'(cf_q);
				mul_b   = 33'(ambient_q) - 33'(temp_q);
				state_d = ST_R_COOL;
			end
			ST_R_COOL: begin
				mul_a   = 33'(torque_q);
				mul_b   = 33'(speed_q);
				state_d = ST_R_PWR;
			end
			ST_R_PWR: state_d = ST_DONE;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= '0;
			torque_q <= '0;
			temp_q   <= 32'sd1310720;
			heat_q   <= '0;
			cool_q   <= '0;
			power_q  <= '0;
			k_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) dt_q <= time_step;
				end
				ST_START_RD: begin
					torque_q <= rd_pt.torque;
					speed_q  <= rd_pt.speed;
					temp_q   <= ambient_q;
				end
				ST_ACC_DIV: begin
					if (div_rsp.done) begin
						if (!torque_q[31]) begin
							accel_q <= (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
						end else begin
							accel_q <= (q > 64'd2147483648) ? 32'sh80000000 : 32'(-q);
						end
					end
				end
				ST_SPD_ADD: begin
					speed_q <= sat32(64'(speed_q) + p16);
					k_q     <= '0;
				end
				ST_SRCH_WAIT: begin
					if (k_q == n_act) torque_q <= prev_q.torque;
				end
				ST_SRCH_CMP: begin
					if (rd_pt.speed < speed_q) begin
						prev_q <= rd_pt;
						k_q    <= k_q + KW'(1);
					end else if (k_q == '0) begin
						torque_q <= rd_pt.torque;
					end else begin
						cur_q <= rd_pt;
					end
				end
				ST_INT_DIV: if (div_rsp.done) t_q <= q[30:0];
				ST_INT_ADD: torque_q <= prev_q.torque + 32'(mul_p >>> 30);
				ST_TMP_M2:  acc_q <= p16;
				ST_TMP_ADD: temp_q <= sat32(64'(temp_q) + acc_q + p16);
				ST_R_SQ2:   sq_q <= (p16 > 64'sd2147483647) ? 32'sh7fffffff : p16[31:0];
				ST_R_H1:    acc_q <= p16;
				ST_R_H2:    heat_q <= sat32(acc_q + p16);
				ST_R_COOL:  cool_q <= sat32(p16);
				ST_R_PWR:   power_q <= p16[47:0];
				// point the curve read port at entry 0 before the next transaction
				ST_DONE:    k_q <= '0;
				default: ;
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = (state_q == ST_DONE);
	assign speed_out        = speed_q;
	assign torque_out       = torque_q;
	assign power_out        = power_q;
	assign temperature_out  = temp_q;
	assign temp_change_rate = sat32(64'(heat_q) + 64'(cool_q));
	assign overheated       = (temp_q >= overheat_q);

	`ESTC_AST_IMP(a_out_blocks_in, out_valid, in_stall)
	`ESTC_AST_IMP(a_div_done_waited, div_rsp.done, state_q == ST_ACC_DIV || state_q == ST_INT_DIV)
	`ESTC_AST_IMP(a_idle_div_free, state_q == ST_IDLE, !div_rsp.busy)
	`ESTC_AST_NXT(a_accept_busy, accept, in_stall)
endmodule

### test/engine_speed_thermal_step_core_tb.sv
// Self-checking testbench for the engine speed and thermal step core
`timescale 1ns / 1ps

module engine_speed_thermal_step_core_tb;
	import estc_pkg::*;

	localparam logic [1:0] REQ_NONE  = 2'd3;
	localparam logic [2:0] CFG_SPARE = 3'd7;
	localparam int         NPTS      = 8;
	localparam int         HOLD_CYC  = 400;
	localparam longint     I32_MAX   = 64'sd2147483647;
	localparam longint     I32_MIN   = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [31:0] torque;
		logic signed [47:0] power;
		logic signed [31:0] temp;
		logic signed [31:0] rate;
		logic               hot;
	} engine_view_t;

	typedef struct {
		logic [1:0]         kind;
		logic [2:0]         idx;
		logic signed [31:0] pt_trq;
		logic signed [31:0] pt_spd;
		logic [23:0]        dt;
		bit                 at_reset;
	} stim_row_t;

	localparam engine_view_t RESET_VIEW = '{speed: 32'sd0, torque: 32'sd0, power: 48'sd0,
		temp: 32'sd1310720, rate: 32'sd0, hot: 1'b0};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [2:0]         point_index;
	logic signed [31:0] point_torque;
	logic signed [31:0] point_speed;
	logic [23:0]        time_step;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] speed_out;
	logic signed [31:0] torque_out;
	logic signed [47:0] power_out;
	logic signed [31:0] temperature_out;
	logic signed [31:0] temp_change_rate;
	logic               overheated;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;

	engine_speed_thermal_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .point_index(point_index), .point_torque(point_torque),
		.point_speed(point_speed), .time_step(time_step),
		.out_valid(out_valid), .out_stall(out_stall),
		.speed_out(speed_out), .torque_out(torque_out), .power_out(power_out),
		.temperature_out(temperature_out), .temp_change_rate(temp_change_rate),
		.overheated(overheated),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// engine state mirror
	longint     m_inertia, m_limit, m_hpt, m_hps, m_cool_f, m_ambient;
	logic [3:0] m_points;
	longint     c_trq [NPTS];
	longint     c_spd [NPTS];
	longint     m_speed, m_torque, m_temp, m_heat, m_cool;

	engine_view_t pending_views[$];
	int  n_items, n_results, n_ticks, n_phases, n_mismatch;
	int  burst_left, gap_len;
	bit  hold_req;
	bit  hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("engine_speed_thermal_step_core test failed");
		$finish;
	end

	function automatic longint sat32(input longint v);
		if (v > I32_MAX) return I32_MAX;
		if (v < I32_MIN) return I32_MIN;
		return v;
	endfunction

	function automatic void update_rates();
		longint sq;
		sq = (m_speed * m_speed) >>> 16;
		if (sq > I32_MAX) sq = I32_MAX;
		m_heat = sat32(((m_torque * m_hpt) >>> 16) + ((sq * m_hps) >>> 16));
		m_cool = sat32((m_cool_f * (m_ambient - m_temp)) >>> 16);
	endfunction

	function automatic engine_view_t engine_step(input stim_row_t r);
		longint inr, acc, dtv, dtemp, n, j, v1, v2, m1, m2, tt;
		longint unsigned num, den;
		engine_view_t v;
		dtv = longint'(r.dt);
		case (r.kind)
			REQ_LOAD: begin
				c_trq[r.idx] = longint'(r.pt_trq);
				c_spd[r.idx] = longint'(r.pt_spd);
			end
			REQ_START: begin
				m_torque = c_trq[0];
				m_speed  = c_spd[0];
				m_temp   = m_ambient;
				update_rates();
			end
			REQ_TICK: begin
				inr = (m_inertia == 0) ? 1 : m_inertia;
				acc = sat32((m_torque * 65536) / inr);
				m_speed = sat32(m_speed + ((acc * dtv) >>> 16));
				n = (m_points == 0) ? 1 : ((m_points > NPTS) ? NPTS : m_points);
				j = 0;
				while (j < n && c_spd[j] < m_speed) j++;
				if (j == 0) begin
					m_torque = c_trq[0];
				end else if (j == n) begin
					m_torque = c_trq[n - 1];
				end else begin
					v1 = c_spd[j - 1];
					v2 = c_spd[j];
					m1 = c_trq[j - 1];
					m2 = c_trq[j];
					num = longint'(m_speed - v1) << 30;
					den = v2 - v1;
					tt = longint'(num / den);
					m_torque = m1 + (((m2 - m1) * tt) >>> 30);
				end
				dtemp = ((m_heat * dtv) >>> 16) + ((m_cool * dtv) >>> 16);
				m_temp = sat32(m_temp + dtemp);
				update_rates();
			end
			default: ;
		endcase
		v.speed  = m_speed[31:0];
		v.torque = m_torque[31:0];
		v.power  = 48'((m_torque * m_speed) >>> 16);
		v.temp   = m_temp[31:0];
		v.rate   = 32'(sat32(m_heat + m_cool));
		v.hot    = (m_temp >= m_limit);
		return v;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		n_mismatch++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	// scoreboard
	always @(posedge clk) begin
		engine_view_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_views.size() == 0) begin
				n_mismatch++;
				$display("[%0t] result with no transaction pending", $time);
			end else begin
				w = pending_views.pop_front();
				if (speed_out !== w.speed) report_mismatch("speed_out", speed_out, w.speed);
				if (torque_out !== w.torque) report_mismatch("torque_out", torque_out, w.torque);
				if (power_out !== w.power) report_mismatch("power_out", power_out, w.power);
				if (temperature_out !== w.temp)
					report_mismatch("temperature_out", temperature_out, w.temp);
				if (temp_change_rate !== w.rate)
					report_mismatch("temp_change_rate", temp_change_rate, w.rate);
				if (overheated !== w.hot) report_mismatch("overheated", overheated, w.hot);
			end
		end
	end

	// output back-pressure
	initial begin
		int mode, cnt;
		out_stall = 1'b0;
		mode = 0;
		cnt = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (cnt == 0) begin
					mode = $urandom_range(0, 2);
					cnt = $urandom_range(16, 128);
				end
				cnt--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					default: out_stall <= ($urandom_range(0, 99) < 75);
				endcase
			end
		end
	end

	task automatic send_item(input stim_row_t r);
		engine_view_t v;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len) @(negedge clk);
			burst_left = $urandom_range(1, 12);
			gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
		end
		req_type     <= r.kind;
		point_index  <= r.idx;
		point_torque <= r.pt_trq;
		point_speed  <= r.pt_spd;
		time_step    <= r.dt;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		v = engine_step(r);
		pending_views.push_back(r.at_reset ? RESET_VIEW : v);
		n_items++;
		if (r.kind == REQ_TICK) n_ticks++;
		if (n_items == 300) hold_req = 1'b1;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_views.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_INERTIA:    m_inertia = longint'({1'b0, data[30:0]});
			CFG_OVERHEAT:   m_limit   = longint'(signed'(data));
			CFG_HEAT_TRQ:   m_hpt     = longint'(signed'(data));
			CFG_HEAT_SPDSQ: m_hps     = longint'(signed'(data));
			CFG_COOLING:    m_cool_f  = longint'(signed'(data));
			CFG_AMBIENT:    m_ambient = longint'(signed'(data));
			CFG_POINTS:     m_points  = data[3:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			3: return 32'd0;
			default: return $urandom_range(0, 2048) - 1024;
		endcase
	endfunction

	task automatic random_config();
		logic [31:0] inr;
		case ($urandom_range(0, 5))
			0: inr = 32'd1;
			1: inr = 32'h7fffffff;
			2: inr = $urandom;
			3: inr = 32'h80000000;
			default: inr = $urandom_range(32'h8000, 32'h400000);
		endcase
		write_reg(CFG_INERTIA, inr);
		write_reg(CFG_OVERHEAT, ($urandom_range(0, 4) == 0) ? $urandom
			: $urandom_range(0, 32'h2000000));
		write_reg(CFG_HEAT_TRQ, pick_coef());
		write_reg(CFG_HEAT_SPDSQ, pick_coef());
		write_reg(CFG_COOLING, pick_coef());
		write_reg(CFG_AMBIENT, ($urandom_range(0, 4) == 0) ? $urandom
			: $urandom_range(0, 32'h1000000));
		write_reg(CFG_POINTS, ($urandom_range(0, 3) == 0) ? $urandom
			: $urandom_range(1, NPTS));
		if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic load_curve();
		stim_row_t r;
		longint spd;
		bit wide, scramble;
		wide = ($urandom_range(0, 4) == 0);
		scramble = ($urandom_range(0, 9) == 0);
		spd = longint'($signed($urandom)) >>> (wide ? 1 : 6);
		for (int i = 0; i < NPTS; i++) begin
			r.kind = REQ_LOAD;
			r.idx = 3'(i);
			r.pt_spd = scramble ? $urandom : spd[31:0];
			r.pt_trq = wide ? $urandom : ($signed($urandom) >>> 10);
			r.dt = 24'($urandom);
			r.at_reset = 1'b0;
			send_item(r);
			spd = sat32(spd + $urandom_range(1, wide ? 32'h3fffffff : 32'h800000));
		end
	endtask

	task automatic random_item(input logic [1:0] kind);
		stim_row_t r;
		r.kind = kind;
		r.idx = 3'($urandom);
		r.pt_trq = $urandom;
		r.pt_spd = $urandom;
		case ($urandom_range(0, 9))
			0: r.dt = 24'($urandom);
			1: r.dt = 24'hffffff;
			2: r.dt = 24'd0;
			default: r.dt = 24'($urandom_range(1, 8192));
		endcase
		r.at_reset = 1'b0;
		send_item(r);
	endtask

	initial begin
		stim_row_t dir_rows[$];
		stim_row_t r;
		int ticks, pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		point_index = '0;
		point_torque = '0;
		point_speed = '0;
		time_step = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_INERTIA;
		cfg_wdata = '0;
		hold_req = 1'b0;
		n_items = 0; n_results = 0; n_ticks = 0; n_phases = 0; n_mismatch = 0;
		burst_left = 4; gap_len = 2;
		m_inertia = 65536; m_limit = 7208960; m_hpt = 0; m_hps = 0; m_cool_f = 0;
		m_ambient = 1310720; m_points = 1;
		m_speed = 0; m_torque = 0; m_temp = 1310720; m_heat = 0; m_cool = 0;
		foreach (c_trq[i]) begin
			c_trq[i] = 0;
			c_spd[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// curve loads and an unknown request leave the engine state at its reset values; then start and ticks
		dir_rows.push_back('{REQ_LOAD, 3'd0, 32'sh7fffffff, 32'sh80000000, 24'hffffff, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd1, 32'sh80000000, -32'sd65536, 24'd0, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd2, 32'sd65536, 32'sd0, 24'd1, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd3, 32'sd131072, 32'sd65536, 24'd2, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd4, -32'sd131072, 32'sd655360, 24'd3, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd5, 32'sd0, 32'sd6553600, 24'd4, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd6, 32'sd1000000, 32'sd65536000, 24'd5, 1'b1});
		dir_rows.push_back('{REQ_LOAD, 3'd7, -32'sd1, 32'sh7fffffff, 24'haaaaaa, 1'b1});
		dir_rows.push_back('{REQ_NONE, 3'd7, 32'sd5, 32'sd5, 24'h555555, 1'b1});
		dir_rows.push_back('{REQ_START, 3'd0, 32'sd0, 32'sd0, 24'd0, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'd0, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'hffffff, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'd1, 1'b0});
		dir_rows.push_back('{REQ_NONE, 3'd2, 32'sd0, 32'sd0, 24'd0, 1'b0});
		foreach (dir_rows[i]) send_item(dir_rows[i]);

		// zero points, full curve, extreme coefficients and inertia
		drain_block();
		write_reg(CFG_POINTS, 32'd0);
		write_reg(CFG_INERTIA, 32'd0);
		write_reg(CFG_HEAT_TRQ, 32'h7fffffff);
		write_reg(CFG_HEAT_SPDSQ, 32'h80000000);
		write_reg(CFG_COOLING, 32'h80000000);
		write_reg(CFG_AMBIENT, 32'h7fffffff);
		write_reg(CFG_OVERHEAT, 32'h80000000);
		cfg_we <= 1'b0;
		dir_rows.delete();
		dir_rows.push_back('{REQ_START, 3'd0, 32'sd0, 32'sd0, 24'd0, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'hffffff, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'h10000, 1'b0});
		foreach (dir_rows[i]) send_item(dir_rows[i]);
		drain_block();
		write_reg(CFG_POINTS, 32'd15);
		write_reg(CFG_INERTIA, 32'hffffffff);
		write_reg(CFG_COOLING, 32'h7fffffff);
		write_reg(CFG_AMBIENT, 32'h80000000);
		write_reg(CFG_OVERHEAT, 32'h7fffffff);
		cfg_we <= 1'b0;
		dir_rows.delete();
		dir_rows.push_back('{REQ_START, 3'd0, 32'sd0, 32'sd0, 24'd0, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'hffffff, 1'b0});
		dir_rows.push_back('{REQ_TICK, 3'd0, 32'sd0, 32'sd0, 24'd7, 1'b0});
		foreach (dir_rows[i]) send_item(dir_rows[i]);

		// random phases: reconfigure, load a curve, start, then run ticks with noise
		while (n_items < 820) begin
			drain_block();
			random_config();
			n_phases++;
			load_curve();
			random_item(REQ_START);
			ticks = $urandom_range(15, 60);
			for (int k = 0; k < ticks; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 86) random_item(REQ_TICK);
				else if (pick < 91) random_item(REQ_LOAD);
				else if (pick < 95) random_item(REQ_NONE);
				else random_item(REQ_START);
			end
		end

		drain_block();
		repeat (300) @(posedge clk);
		$display("Ran %0d transactions (%0d ticks) over %0d random register settings;",
			n_items, n_ticks, n_phases);
		$display("checked %0d results, %0d mismatches.", n_results, n_mismatch);
		if (n_mismatch == 0 && pending_views.size() == 0) begin
			$display("engine_speed_thermal_step_core test passed");
		end else begin
			$display("engine_speed_thermal_step_core test failed");
		end
		$finish;
	end

endmodule
